// File: sv/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median
// Sample width, default window length, request codes and the link record
// that runs between neighboring cells of the sorted window.
// ----------------------------------------------------------------------------
package swm_pkg;

  // data path width, signed Q16.16
  localparam int unsigned DataW = 32;

  // default window length
  localparam int unsigned DefWindow = 7;

  // request codes
  typedef enum logic [0:0] {
    REQ_SAMPLE = 1'b0,
    REQ_FILL   = 1'b1
  } swm_req_e;

  // data handed from one cell to its right neighbor
  typedef struct packed {
    logic                    found;       // oldest slot seen at or left of this cell
    logic                    hit;         // insert point seen at or left of this cell
    logic signed [DataW-1:0] kept_value;  // value of this kept position
  } swm_link_t;

endpackage

// File: sv/swm_if.sv
// ----------------------------------------------------------------------------
// swm interfaces: valid/ready channels of the sliding window median
// One interface for the sample channel and one for the median channel.
// ----------------------------------------------------------------------------
interface swm_in_if import swm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  swm_req_e                req_type;
  logic signed [DataW-1:0] sample_value;

  modport source (output valid, output req_type, output sample_value, input ready);
  modport sink   (input valid, input req_type, input sample_value, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] median_value;

  modport source (output valid, output median_value, input ready);
  modport sink   (input valid, input median_value, output ready);
endinterface

// File: sv/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window
// Holds a value and its age. On a sample it takes its new contents from
// itself, its neighbors or the sample, so the row drops the oldest slot and
// inserts the new one in the same update.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; #(
  parameter int unsigned WINDOW = DefWindow,
  parameter int unsigned IDX    = 0,
  localparam int unsigned AgeW  = $clog2(WINDOW)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    fill_i,
  input  logic signed [DataW-1:0] sample_i,
  input  swm_link_t               left_i,
  input  logic [AgeW-1:0]         left_age_i,
  input  logic signed [DataW-1:0] right_value_i,
  input  logic [AgeW-1:0]         right_age_i,
  output swm_link_t               right_o,
  output logic [AgeW-1:0]         right_age_o,
  output logic signed [DataW-1:0] value_o,
  output logic [AgeW-1:0]         age_o
);

  localparam logic [AgeW-1:0] OldAge   = AgeW'(WINDOW - 1);
  localparam logic [AgeW-1:0] ResetAge = AgeW'(IDX);
  localparam logic            IsLast   = (IDX == WINDOW - 1);

  logic signed [DataW-1:0] value_q, value_d;
  logic [AgeW-1:0]         age_q, age_d;
  logic                    found;
  logic                    greater;
  logic signed [DataW-1:0] kept_value;
  logic [AgeW-1:0]         kept_age;

  // slots right of the dropped one shift left by one
  assign found      = left_i.found | (age_q == OldAge);
  assign kept_value = found ? right_value_i : value_q;
  assign kept_age   = found ? right_age_i : age_q;

  // insert before the first kept value strictly greater than the sample
  assign greater = IsLast | (sample_i < kept_value);

  assign right_o.found      = found;
  assign right_o.hit        = left_i.hit | greater;
  assign right_o.kept_value = kept_value;
  assign right_age_o        = kept_age;

  // next slot contents
  always_comb begin
    value_d = value_q;
    age_d   = age_q;
    if (fill_i) begin
      value_d = sample_i;
    end else if (left_i.hit) begin
      value_d = left_i.kept_value;
      age_d   = left_age_i + AgeW'(1);
    end else if (greater) begin
      value_d = sample_i;
      age_d   = '0;
    end else begin
      value_d = kept_value;
      age_d   = kept_age + AgeW'(1);
    end
  end

  // slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      age_q   <= ResetAge;
    end else if (en_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign value_o = value_q;
  assign age_o   = age_q;

endmodule

// File: sv/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_core: running median over the last WINDOW samples
// A row of cells keeps the window sorted with age tags; the median is read
// from the middle of the row and held until the sink takes it.
// ----------------------------------------------------------------------------
//
//  channel    dir  payload                       transaction
//  ---------  ---  ----------------------------  ------------------------------
//  sample_i   in   req_type, sample_value        sample or fill request
//  result_o   out  median_value                  median after each sample
//
//  One request per cycle unless a median waits unread: the whole cell row
//  updates in the cycle the request is taken; the median shows the next cycle.
//  A fill request updates every value and gives no median.
//  Reset clears all values to zero and sets each age to its slot index.
//  While a median waits on result_o, a new request is taken only in the
//  cycle the median is taken.
//
module sliding_window_median_core import swm_pkg::*; #(
  parameter int unsigned WINDOW = DefWindow,
  localparam int unsigned AgeW  = $clog2(WINDOW)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swm_in_if.sink    sample_i,
  swm_out_if.source result_o
);

  localparam int unsigned MidHi = WINDOW / 2;
  localparam int unsigned MidLo = (WINDOW - 1) / 2;

  logic                    accept;
  logic                    fill;
  logic                    out_valid_q, out_valid_d;
  swm_link_t               link   [WINDOW+1];
  logic [AgeW-1:0]         kage   [WINDOW+1];
  logic signed [DataW-1:0] value  [WINDOW+1];
  logic [AgeW-1:0]         age    [WINDOW+1];
  logic signed [DataW:0]   mid_sum;

  // handshake
  assign sample_i.ready = !out_valid_q || result_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;
  assign fill           = (sample_i.req_type == REQ_FILL);

  // boundary of the cell row
  assign link[0]       = '0;
  assign kage[0]       = '0;
  assign value[WINDOW] = '0;
  assign age[WINDOW]   = '0;

  // sorted window
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    swm_cell #(
      .WINDOW (WINDOW),
      .IDX    (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (accept),
      .fill_i        (fill),
      .sample_i      (sample_i.sample_value),
      .left_i        (link[i]),
      .left_age_i    (kage[i]),
      .right_value_i (value[i+1]),
      .right_age_i   (age[i+1]),
      .right_o       (link[i+1]),
      .right_age_o   (kage[i+1]),
      .value_o       (value[i]),
      .age_o         (age[i])
    );
  end

  // median, mean of the two middle slots floored for an even window
  assign mid_sum = {value[MidLo][DataW-1], value[MidLo]}
                 + {value[MidHi][DataW-1], value[MidHi]};
  assign result_o.median_value = mid_sum[DataW:1];

  // result valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = !fill;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid = out_valid_q;

endmodule
